FILE: design/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int CFG_W   = 11;
	localparam int PIX_W   = 8;
	localparam int GRAD_W  = 11;
	localparam int SUM_W   = 21;
	localparam int POS_W   = 10;
	localparam int CLAMP_SUM = 65281;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	typedef logic [2:0][PIX_W-1:0] pix_t;
endpackage

FILE: design/sem_lbuf.sv
`timescale 1ns / 1ps
module sem_lbuf #(
	parameter int DEPTH = sem_pkg::DEF_MAX_WIDTH,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [2*sem_pkg::PIX_W*3-1:0] wr_data,
	output logic [2*sem_pkg::PIX_W*3-1:0] rd_data
);
	import sem_pkg::*;
	logic [2*PIX_W*3-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

FILE: design/sem_sqrt.sv
`timescale 1ns / 1ps
module sem_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [sem_pkg::GRAD_W-1:0] gx [3],
	input  logic signed [sem_pkg::GRAD_W-1:0] gy [3],
	output logic                              done,
	output logic [sem_pkg::PIX_W-1:0]         mag [3]
);
	import sem_pkg::*;
	logic [SUM_W-1:0] s_q [3];
	logic [PIX_W-1:0] q_q [3];
	logic [2:0]       step_q;
	logic             busy_q;
	logic             rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 1'b0;
				step_q <= 3'd7;
			end else if (busy_q && !rnd_q) begin
				if (step_q == 3'd0) rnd_q <= 1'b1;
				else step_q <= step_q - 3'd1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				rnd_q  <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			logic [PIX_W-1:0] t;
			logic [15:0]      tt;
			logic [16:0]      qq;
			t  = q_q[c] | (8'd1 << step_q);
			tt = 16'(t) * 16'(t);
			qq = 17'(q_q[c]) * 17'(q_q[c]) + 17'(q_q[c]);
			if (start) begin
				s_q[c] <= SUM_W'($unsigned(22'(gx[c] * gx[c]) + 22'(gy[c] * gy[c])));
				q_q[c] <= '0;
			end else if (busy_q && !rnd_q) begin
				if ({5'd0, tt} <= s_q[c]) q_q[c] <= t;
			end else if (busy_q) begin
				if (s_q[c] >= SUM_W'(CLAMP_SUM)) mag[c] <= 8'd255;
				else if (s_q[c] > {4'd0, qq}) mag[c] <= q_q[c] + 8'd1;
				else mag[c] <= q_q[c];
			end
		end
	end
endmodule

FILE: design/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
// Flow: an item taken in idle is written to the line memory in S_RD; an item with a result
// then passes S_SUM, S_SQRT and S_OUT, and a right-edge item past the first column runs S_SUM
// to S_OUT again for its second result after the first is transferred. One item at a time;
// s_tready stays low during the bit-serial square root (8 steps plus square and round).
// Reset: counters, window and size registers (width 1, height 1) clear at once; line
// memory contents stay undefined and are masked by the row count.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_addr,
	input  logic [sem_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,  // pixel_blue, pixel_green, pixel_red
	input  logic                      s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,  // out_column, out_row, edge_blue, edge_green, edge_red
	output logic                      m_tlast,  // last_of_step
	output logic                      m_tuser   // frame_done
);
	import sem_pkg::*;
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] width_q, height_q;
	logic [CW-1:0]    w;
	logic [RW-1:0]    h;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             drain_q;
	pix_t             nw_s1;
	pix_t             win_q [3][3];
	logic             have2_q, sel_q, right_q, final_q;
	logic [POS_W-1:0] orow_q, ocol1_q, ocol2_q;
	logic [2*PIX_W*3-1:0] rd_data;
	logic             accept;
	logic             rd_en, wr_en;
	logic signed [GRAD_W-1:0] gx [3];
	logic signed [GRAD_W-1:0] gy [3];
	logic             sq_done;
	logic [PIX_W-1:0] mag [3];
	pix_t             up, lo;
	logic             right_edge;

	always_comb begin
		if (width_q == '0) w = CW'(1);
		else if (32'(width_q) > MAX_WIDTH) w = CW'(MAX_WIDTH);
		else w = CW'(width_q);
		if (height_q == '0) h = RW'(1);
		else if (32'(height_q) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
		else h = RW'(height_q);
	end

	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign rd_en      = accept;
	assign wr_en      = (state_q == S_RD);
	assign up         = (row_q >= RW'(2)) ? rd_data[47:24] : '0;
	assign lo         = (row_q >= RW'(1)) ? rd_data[23:0] : '0;
	assign right_edge = (col_q == w - CW'(1));

	sem_lbuf #(.DEPTH(MAX_WIDTH), .AW(AW)) u_lbuf (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (col_q[AW-1:0]),
		.wr_en   (wr_en),
		.wr_addr (col_q[AW-1:0]),
		.wr_data ({rd_data[23:0], nw_s1}),
		.rd_data (rd_data)
	);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			int p0 [3];
			int p1 [3];
			int p2 [3];
			for (int r = 0; r < 3; r++) begin
				p0[r] = sel_q ? int'(win_q[1][r][c]) : int'(win_q[0][r][c]);
				p1[r] = sel_q ? int'(win_q[2][r][c]) : int'(win_q[1][r][c]);
				p2[r] = sel_q ? 0 : int'(win_q[2][r][c]);
			end
			gx[c] = GRAD_W'((p2[0] + 2 * p2[1] + p2[2]) - (p0[0] + 2 * p0[1] + p0[2]));
			gy[c] = GRAD_W'((p0[2] + 2 * p1[2] + p2[2]) - (p0[0] + 2 * p1[0] + p2[0]));
		end
	end

	sem_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SUM),
		.gx     (gx),
		.gy     (gy),
		.done   (sq_done),
		.mag    (mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= 1'b0;
			have2_q  <= 1'b0;
			sel_q    <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int r = 0; r < 3; r++) win_q[i][r] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (s_tuser == drain_q)) state_q <= S_RD;
				end
				S_RD: begin
					if (col_q == '0) begin
						for (int r = 0; r < 3; r++) begin
							win_q[0][r] <= '0;
							win_q[1][r] <= '0;
						end
					end else begin
						win_q[0] <= win_q[1];
						win_q[1] <= win_q[2];
					end
					win_q[2] <= '{up, lo, nw_s1};
					have2_q  <= (row_q != '0) && right_edge;
					if (col_q + CW'(1) >= w) begin
						col_q <= '0;
						if (drain_q) begin
							row_q   <= '0;
							drain_q <= 1'b0;
						end else begin
							row_q <= row_q + RW'(1);
							if (row_q + RW'(1) >= h) drain_q <= 1'b1;
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
					if ((row_q != '0) && (col_q != '0)) begin
						sel_q   <= 1'b0;
						state_q <= S_SUM;
					end else if ((row_q != '0) && right_edge) begin
						sel_q   <= 1'b1;
						state_q <= S_SUM;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SUM: state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_done) begin
						m_tvalid <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (!sel_q && have2_q) begin
							sel_q   <= 1'b1;
							state_q <= S_SUM;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH: begin
						width_q <= cfg_wdata;
						col_q   <= '0;
						row_q   <= '0;
						drain_q <= 1'b0;
					end
					REG_HEIGHT: begin
						height_q <= cfg_wdata;
						col_q    <= '0;
						row_q    <= '0;
						drain_q  <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] rm1, cm1;
		rm1 = 32'(row_q) - 32'd1;
		cm1 = 32'(col_q) - 32'd1;
		if (accept) begin
			nw_s1 <= s_tuser ? '0 : s_tdata;
		end
		if (state_q == S_RD) begin
			right_q <= right_edge;
			final_q <= right_edge && drain_q;
			orow_q  <= rm1[POS_W-1:0];
			ocol1_q <= cm1[POS_W-1:0];
			ocol2_q <= POS_W'(32'(col_q));
		end
		if ((state_q == S_SQRT) && sq_done) begin
			m_tdata <= {4'd0, sel_q ? ocol2_q : ocol1_q, orow_q, mag[2], mag[1], mag[0]};
			m_tlast <= sel_q ? 1'b1 : !right_q;
			m_tuser <= sel_q ? final_q : 1'b0;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken while a result is pending");
	a_sqrt_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_SQRT)) else $error("root finished outside its wait");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast) else $error("frame end not last of step");
endmodule
